@@ src/tstp_pkg.sv @@
package tstp_pkg;

    localparam int POS_W    = 8;
    localparam int DEPTH_W  = 9;
    localparam int NODE_W   = 8;
    localparam int LABEL_W  = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_POS_OVF = 2'd3
    } status_t;

    // result fields of one item, minus the parent that comes from the stack ram
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [DEPTH_W-1:0] depth;
        logic               is_node;
        logic [NODE_W-1:0]  node_number;
        logic [LABEL_W-1:0] node_label;
        logic               has_parent;
        status_t            status;
    } meta_t;

endpackage

@@ src/tstp_stack_ram.sv @@
module tstp_stack_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tstp_pkg::NODE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [tstp_pkg::NODE_W-1:0] rdata
);

    logic [tstp_pkg::NODE_W-1:0] mem [DEPTH];
    logic [tstp_pkg::NODE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tstp_ctrl.sv @@
module tstp_ctrl #(
    parameter int MAX_LEN    = 256,
    parameter int LABEL_BITS = 16,
    parameter int AW         = $clog2(MAX_LEN)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         start_new,
    input  logic                         is_backtrack,
    input  logic [tstp_pkg::LABEL_W-1:0] label,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [tstp_pkg::NODE_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    output logic                         s1_valid,
    input  logic                         s1_ready,
    output tstp_pkg::meta_t              s1_meta
);

    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int KEPT = (LABEL_BITS < tstp_pkg::LABEL_W) ? LABEL_BITS : tstp_pkg::LABEL_W;

    logic [CW-1:0]   stack_count_reg, stack_count_next;
    logic [CW-1:0]   node_count_reg, node_count_next;
    logic [CW-1:0]   pos_count_reg, pos_count_next;
    logic            s1_valid_reg, s1_valid_next;
    tstp_pkg::meta_t s1_meta_reg, s1_meta_next;

    logic            accept;
    logic [CW-1:0]   cnt_eff, node_eff, pos_eff, cnt_m1;
    logic            pos_ovf, empty, full, push_ok, pop_ok;
    tstp_pkg::status_t status;

    // start_new clears the counters ahead of this item
    assign cnt_eff  = start_new ? '0 : stack_count_reg;
    assign node_eff = start_new ? '0 : node_count_reg;
    assign pos_eff  = start_new ? '0 : pos_count_reg;
    assign cnt_m1   = cnt_eff - CW'(1);

    assign pos_ovf = (pos_eff == CW'(MAX_LEN));
    assign empty   = (cnt_eff == '0);
    assign full    = (cnt_eff == CW'(MAX_LEN));
    assign push_ok = !pos_ovf && !is_backtrack && !full;
    assign pop_ok  = !pos_ovf && is_backtrack && !empty;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (pos_ovf)
        begin
            status = tstp_pkg::STATUS_POS_OVF;
        end
        else if (is_backtrack && empty)
        begin
            status = tstp_pkg::STATUS_EMPTY;
        end
        else if (!is_backtrack && full)
        begin
            status = tstp_pkg::STATUS_FULL;
        end
        else
        begin
            status = tstp_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        stack_count_next = stack_count_reg;
        node_count_next  = node_count_reg;
        pos_count_next   = pos_count_reg;
        if (accept)
        begin
            stack_count_next = cnt_eff;
            node_count_next  = node_eff;
            pos_count_next   = pos_eff;
            if (push_ok)
            begin
                stack_count_next = cnt_eff + CW'(1);
                node_count_next  = node_eff + CW'(1);
                pos_count_next   = pos_eff + CW'(1);
            end
            else if (pop_ok)
            begin
                stack_count_next = cnt_m1;
                pos_count_next   = pos_eff + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_meta_next.position    = tstp_pkg::POS_W'(pos_eff);
        s1_meta_next.depth       = push_ok ? tstp_pkg::DEPTH_W'(cnt_eff + CW'(1))
                                 : pop_ok  ? tstp_pkg::DEPTH_W'(cnt_m1)
                                 :           tstp_pkg::DEPTH_W'(cnt_eff);
        s1_meta_next.is_node     = !is_backtrack;
        s1_meta_next.node_number = push_ok ? tstp_pkg::NODE_W'(node_eff) : '0;
        s1_meta_next.node_label  = push_ok ? tstp_pkg::LABEL_W'(label[KEPT-1:0]) : '0;
        s1_meta_next.has_parent  = push_ok && !empty;
        s1_meta_next.status      = status;
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // push writes the slot above the top, parent reads the top: never the same entry
    assign ram_we    = accept && push_ok;
    assign ram_waddr = cnt_eff[AW-1:0];
    assign ram_wdata = tstp_pkg::NODE_W'(node_eff);
    assign ram_re    = accept && push_ok && !empty;
    assign ram_raddr = cnt_m1[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            node_count_reg  <= '0;
            pos_count_reg   <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            node_count_reg  <= node_count_next;
            pos_count_reg   <= pos_count_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= s1_meta_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_meta  = s1_meta_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= CW'(MAX_LEN))
        else $error("stack count beyond depth");

    a_nodes_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (stack_count_reg <= node_count_reg) && (node_count_reg <= pos_count_reg))
        else $error("counter ordering broken");

    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("stack read and write on the same entry");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push_ok) |=> (stack_count_reg == $past(cnt_eff) + CW'(1)))
        else $error("push did not grow the stack");

endmodule

@@ src/tstp_out.sv @@
module tstp_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    output logic                          s1_ready,
    input  tstp_pkg::meta_t               s1_meta,
    input  logic [tstp_pkg::NODE_W-1:0]   ram_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tstp_pkg::POS_W-1:0]    symbol_position,
    output logic [tstp_pkg::DEPTH_W-1:0]  depth,
    output logic                          is_node,
    output logic [tstp_pkg::NODE_W-1:0]   node_number,
    output logic [tstp_pkg::LABEL_W-1:0]  node_label,
    output logic [tstp_pkg::NODE_W-1:0]   parent_number,
    output logic [tstp_pkg::STATUS_W-1:0] status
);

    logic                          out_valid_reg, out_valid_next;
    logic                          load;
    tstp_pkg::meta_t               meta_reg;
    logic [tstp_pkg::NODE_W-1:0]   parent_reg;

    assign s1_ready = !out_valid_reg || out_ready;
    assign load     = s1_valid && s1_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // ram data lines up with the item in s1, held while s1 stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_reg   <= s1_meta;
            parent_reg <= s1_meta.has_parent ? ram_rdata : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign symbol_position = meta_reg.position;
    assign depth           = meta_reg.depth;
    assign is_node         = meta_reg.is_node;
    assign node_number     = meta_reg.node_number;
    assign node_label      = meta_reg.node_label;
    assign parent_number   = parent_reg;
    assign status          = meta_reg.status;

endmodule

@@ src/tree_string_depth_parent_tracker.sv @@
// preorder tree string decoder: one symbol per input item, one result item per symbol
//
// input channel in_valid/in_ready carries start_new, is_backtrack and label;
// output channel out_valid/out_ready carries position, depth, node number,
// label echo, parent number and status
//
// throughput: one item per cycle while the output is not stalled; only
// counters decide push or pop, and the parent is read from the stack ram, a
// single-port-write, single-read synchronous memory, in the cycle after the
// item is taken; a result passes the middle stage, where the ram read
// lands, and then the output register on its way to the output
//
// reset clears the stack count, node counter and position; the stack ram
// is not cleared, since only entries written since the last restart are read
//
// when the receiver stalls the output register holds, the middle stage
// fills, and then in_ready drops; nothing is lost or repeated
module tree_string_depth_parent_tracker #(
    parameter int MAX_LEN    = 256,
    parameter int LABEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_new,
    input  logic                          is_backtrack,
    input  logic [tstp_pkg::LABEL_W-1:0]  label,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tstp_pkg::POS_W-1:0]    symbol_position,
    output logic [tstp_pkg::DEPTH_W-1:0]  depth,
    output logic                          is_node,
    output logic [tstp_pkg::NODE_W-1:0]   node_number,
    output logic [tstp_pkg::LABEL_W-1:0]  node_label,
    output logic [tstp_pkg::NODE_W-1:0]   parent_number,
    output logic [tstp_pkg::STATUS_W-1:0] status
);

    localparam int AW = $clog2(MAX_LEN);

    // stack ram ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tstp_pkg::NODE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tstp_pkg::NODE_W-1:0] ram_rdata;

    // middle stage between control and output register
    logic            s1_valid;
    logic            s1_ready;
    tstp_pkg::meta_t s1_meta;

    // counters, status decision and stack addressing
    tstp_ctrl #(
        .MAX_LEN    (MAX_LEN),
        .LABEL_BITS (LABEL_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_new    (start_new),
        .is_backtrack (is_backtrack),
        .label        (label),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_meta      (s1_meta)
    );

    // node numbers of open nodes, top at stack_count - 1
    tstp_stack_ram #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register, merges the parent read with the item
    tstp_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .s1_ready        (s1_ready),
        .s1_meta         (s1_meta),
        .ram_rdata       (ram_rdata),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .symbol_position (symbol_position),
        .depth           (depth),
        .is_node         (is_node),
        .node_number     (node_number),
        .node_label      (node_label),
        .parent_number   (parent_number),
        .status          (status)
    );

endmodule

@@ tb/tb_tree_string_depth_parent_tracker.sv @@
`timescale 1ns / 1ps

module tb_tree_string_depth_parent_tracker;

    // block sizes, as instantiated
    localparam int MAX_LEN        = 256;
    localparam int NUM_DIR        = 20;
    localparam int RX_HOLD_CYCLES = 80;
    // about this many input items in all, directed rows included
    localparam int TOTAL_ITEMS    = 450;

    // one result item, field for field as on the output ports
    typedef struct packed {
        logic [tstp_pkg::POS_W-1:0]   position;
        logic [tstp_pkg::DEPTH_W-1:0] depth;
        logic                         is_node;
        logic [tstp_pkg::NODE_W-1:0]  node_number;
        logic [tstp_pkg::LABEL_W-1:0] node_label;
        logic [tstp_pkg::NODE_W-1:0]  parent_number;
        tstp_pkg::status_t            status;
    } result_t;

    // one row of the directed table; fixed marks a row whose result is typed in
    typedef struct packed {
        logic                         sn;
        logic                         bt;
        logic [tstp_pkg::LABEL_W-1:0] lab;
        logic                         fixed;
        result_t                      want;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          start_new = 1'b0;
    logic                          is_backtrack = 1'b0;
    logic [tstp_pkg::LABEL_W-1:0]  label = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [tstp_pkg::POS_W-1:0]    symbol_position;
    logic [tstp_pkg::DEPTH_W-1:0]  depth;
    logic                          is_node;
    logic [tstp_pkg::NODE_W-1:0]   node_number;
    logic [tstp_pkg::LABEL_W-1:0]  node_label;
    logic [tstp_pkg::NODE_W-1:0]   parent_number;
    logic [tstp_pkg::STATUS_W-1:0] status;

    // shadow decoder state
    logic [tstp_pkg::NODE_W-1:0]  tree_stack [0:MAX_LEN-1];
    logic [8:0]                   open_count = '0;
    logic [8:0]                   label_count = '0;
    logic [8:0]                   sym_pos = '0;

    // results still owed by the block, oldest first
    result_t            pending_results [$];
    result_t            head_result;
    dir_row_t           dir_rows [0:NUM_DIR-1];

    int                 mismatch_count = 0;
    int                 sent_random = 0;
    bit                 tx_quiet = 1'b0;
    bit                 rx_quiet = 1'b0;
    bit                 rx_hold_req = 1'b0;

    tree_string_depth_parent_tracker #(
        .MAX_LEN    (MAX_LEN),
        .LABEL_BITS (tstp_pkg::LABEL_W)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .start_new       (start_new),
        .is_backtrack    (is_backtrack),
        .label           (label),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .symbol_position (symbol_position),
        .depth           (depth),
        .is_node         (is_node),
        .node_number     (node_number),
        .node_label      (node_label),
        .parent_number   (parent_number),
        .status          (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #3_000_000;
        $display("tree_string_depth_parent_tracker test failed");
        $finish;
    end

    // decode one accepted symbol and advance the shadow state
    function automatic result_t decode_symbol(logic sn, logic bt,
                                              logic [tstp_pkg::LABEL_W-1:0] lab);
        result_t r;
        r = '0;
        // a restart clears everything before the symbol is looked at
        if (sn)
        begin
            open_count  = '0;
            label_count = '0;
            sym_pos     = '0;
        end
        r.position = sym_pos[tstp_pkg::POS_W-1:0];
        r.is_node  = !bt;
        r.status   = tstp_pkg::STATUS_OK;
        if (sym_pos >= MAX_LEN)
        begin
            // string too long: nothing moves
            r.status = tstp_pkg::STATUS_POS_OVF;
        end
        else if (bt)
        begin
            if (open_count == 0)
                r.status = tstp_pkg::STATUS_EMPTY;
            else
            begin
                open_count = open_count - 9'd1;
                sym_pos    = sym_pos + 9'd1;
            end
        end
        else if (open_count >= MAX_LEN)
        begin
            r.status = tstp_pkg::STATUS_FULL;
        end
        else
        begin
            // parent is the node on top before the push, 0 for a root
            if (open_count != 0)
                r.parent_number = tree_stack[8'(open_count - 9'd1)];
            r.node_number = label_count[tstp_pkg::NODE_W-1:0];
            r.node_label  = lab;
            tree_stack[open_count[7:0]] = label_count[tstp_pkg::NODE_W-1:0];
            open_count  = open_count + 9'd1;
            label_count = label_count + 9'd1;
            sym_pos     = sym_pos + 9'd1;
        end
        r.depth = open_count;
        return r;
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // offer one item, hold it until taken, then queue what it should produce
    task automatic offer_symbol(logic sn, logic bt, logic [tstp_pkg::LABEL_W-1:0] lab,
                                logic fixed, result_t want);
        int gap;
        result_t predicted;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        start_new    <= sn;
        is_backtrack <= bt;
        label        <= lab;
        do @(posedge clk); while (!in_ready);
        // shadow state moves on every item, typed rows included
        predicted = decode_symbol(sn, bt, lab);
        pending_results.insert(pending_results.size(), fixed ? want : predicted);
    endtask

    // one tree string: restart on the first symbol, random shape after it
    // bt_pct of 0 builds a chain of labels down to the full stack depth
    task automatic send_tree_string(int len, int bt_pct);
        logic sn;
        logic bt;
        logic [tstp_pkg::LABEL_W-1:0] lab;
        int r;
        for (int i = 0; i < len; i++)
        begin
            sn = (i == 0) || (bt_pct != 0 && $urandom_range(0, 99) < 2);
            if (bt_pct == 0)
                bt = (i >= MAX_LEN) ? 1'($urandom_range(0, 1)) : 1'b0;
            else if (open_count == 0)
                bt = ($urandom_range(0, 99) < 5);   // backtrack on empty, now and then
            else
                bt = ($urandom_range(0, 99) < bt_pct);
            r = $urandom_range(0, 99);
            if (r < 10)
                lab = '0;
            else if (r < 20)
                lab = '1;
            else
                lab = tstp_pkg::LABEL_W'($urandom_range(0, 65535));
            offer_symbol(sn, bt, lab, 1'b0, '0);
            sent_random++;
        end
    endtask

    // sender stands still until every owed result is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // receiver: random ready with gaps, plus one long hold on request
    initial
    begin
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_quiet || $urandom_range(0, 99) < 70)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge clk);
            end
        end
    end

    // compare each taken result with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: pos %0d status %0d",
                       symbol_position, status);
                mismatch_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (symbol_position !== head_result.position)
                begin
                    $error("symbol_position exp %0d got %0d",
                           head_result.position, symbol_position);
                    mismatch_count++;
                end
                if (depth !== head_result.depth)
                begin
                    $error("depth exp %0d got %0d", head_result.depth, depth);
                    mismatch_count++;
                end
                if (is_node !== head_result.is_node)
                begin
                    $error("is_node exp %0d got %0d", head_result.is_node, is_node);
                    mismatch_count++;
                end
                if (node_number !== head_result.node_number)
                begin
                    $error("node_number exp %0d got %0d",
                           head_result.node_number, node_number);
                    mismatch_count++;
                end
                if (node_label !== head_result.node_label)
                begin
                    $error("node_label exp %h got %h", head_result.node_label, node_label);
                    mismatch_count++;
                end
                if (parent_number !== head_result.parent_number)
                begin
                    $error("parent_number exp %0d got %0d",
                           head_result.parent_number, parent_number);
                    mismatch_count++;
                end
                if (status !== head_result.status)
                begin
                    $error("status exp %0d got %0d", head_result.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        // directed rows: sn, bt, label, typed, expected
        // expected order: pos, depth, is_node, node, label, parent, status
        dir_rows = '{
            // backtrack right after reset: empty stack
            '{1'b0, 1'b1, 16'h0000, 1'b1,
              '{8'd0, 9'd0, 1'b0, 8'd0, 16'h0000, 8'd0, tstp_pkg::STATUS_EMPTY}},
            // first root, all-zero label
            '{1'b0, 1'b0, 16'h0000, 1'b1,
              '{8'd0, 9'd1, 1'b1, 8'd0, 16'h0000, 8'd0, tstp_pkg::STATUS_OK}},
            // child of node 0, all-ones label
            '{1'b0, 1'b0, 16'hFFFF, 1'b1,
              '{8'd1, 9'd2, 1'b1, 8'd1, 16'hFFFF, 8'd0, tstp_pkg::STATUS_OK}},
            '{1'b0, 1'b0, 16'h1234, 1'b0, '0},
            '{1'b0, 1'b1, 16'h0000, 1'b0, '0},
            // label on a backtrack is ignored
            '{1'b0, 1'b1, 16'hFFFF, 1'b0, '0},
            '{1'b0, 1'b1, 16'h0000, 1'b0, '0},
            // one backtrack too many: position does not move
            '{1'b0, 1'b1, 16'h0000, 1'b1,
              '{8'd6, 9'd0, 1'b0, 8'd0, 16'h0000, 8'd0, tstp_pkg::STATUS_EMPTY}},
            // second root in the same string
            '{1'b0, 1'b0, 16'hA5A5, 1'b0, '0},
            // restart on a label
            '{1'b1, 1'b0, 16'h5A5A, 1'b1,
              '{8'd0, 9'd1, 1'b1, 8'd0, 16'h5A5A, 8'd0, tstp_pkg::STATUS_OK}},
            // restart on a backtrack: empty at once
            '{1'b1, 1'b1, 16'h0000, 1'b1,
              '{8'd0, 9'd0, 1'b0, 8'd0, 16'h0000, 8'd0, tstp_pkg::STATUS_EMPTY}},
            '{1'b0, 1'b0, 16'h0001, 1'b0, '0},
            '{1'b0, 1'b0, 16'h8000, 1'b0, '0},
            '{1'b0, 1'b1, 16'h7FFF, 1'b0, '0},
            '{1'b0, 1'b0, 16'h00FF, 1'b0, '0},
            '{1'b0, 1'b0, 16'hFF00, 1'b0, '0},
            '{1'b0, 1'b1, 16'h0000, 1'b0, '0},
            '{1'b0, 1'b1, 16'h0000, 1'b0, '0},
            '{1'b1, 1'b0, 16'hFFFF, 1'b1,
              '{8'd0, 9'd1, 1'b1, 8'd0, 16'hFFFF, 8'd0, tstp_pkg::STATUS_OK}},
            '{1'b0, 1'b0, 16'h0000, 1'b0, '0}
        };

        // hold reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            offer_symbol(dir_rows[i].sn, dir_rows[i].bt, dir_rows[i].lab,
                         dir_rows[i].fixed, dir_rows[i].want);
        wait_for_drain();

        // receiver holds off while the sender keeps offering: block fills and stalls
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        send_tree_string(40, 35);
        tx_quiet    = 1'b0;
        wait_for_drain();

        // full-depth chain: depth 256, then position overflow
        send_tree_string(MAX_LEN + 4, 0);
        wait_for_drain();

        // random strings, first with no idling on either side
        rx_quiet = 1'b1;
        tx_quiet = 1'b1;
        while (sent_random < TOTAL_ITEMS - NUM_DIR - 60)
            send_tree_string(($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                          : $urandom_range(25, 60),
                             $urandom_range(25, 50));
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        while (sent_random < TOTAL_ITEMS - NUM_DIR)
            send_tree_string(($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                          : $urandom_range(25, 60),
                             $urandom_range(25, 50));
        wait_for_drain();

        // a little longer, to catch stray results
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tree_string_depth_parent_tracker test passed");
        else
            $display("tree_string_depth_parent_tracker test failed");
        $finish;
    end

endmodule
